### hw/rtl/rpnse_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rpnse_pkg;

  localparam int STACK_DEPTH_DEF = 16;
  localparam int WORD_W          = 64;

  typedef enum logic [4:0] {
    OP_ADD  = 5'd0,  OP_SUB  = 5'd1,  OP_MUL  = 5'd2,  OP_DIV  = 5'd3,
    OP_MOD  = 5'd4,  OP_OR   = 5'd5,  OP_AND  = 5'd6,  OP_XOR  = 5'd7,
    OP_BNOT = 5'd8,  OP_SHL  = 5'd9,  OP_SHR  = 5'd10, OP_LAND = 5'd11,
    OP_LOR  = 5'd12, OP_LXOR = 5'd13, OP_LNOT = 5'd14, OP_LT   = 5'd15,
    OP_LE   = 5'd16, OP_GT   = 5'd17, OP_GE   = 5'd18, OP_EQ   = 5'd19,
    OP_NE   = 5'd20, OP_IF   = 5'd21
  } op_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_UNDER   = 3'd1,
    ST_OVER    = 3'd2,
    ST_DIVZ    = 3'd3,
    ST_NONBOOL = 3'd4,
    ST_EMPTY   = 3'd5,
    ST_MANY    = 3'd6,
    ST_SHIFT   = 3'd7
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_IF,
    S_ITER,
    S_FIN,
    S_OUT
  } state_t;

  localparam logic CMD_PUSH = 1'b0;

  // Number of operands an operator takes; zero marks an unused code.
  function automatic logic [1:0] arity(input logic [4:0] op);
    logic [1:0] n;
    if (op == OP_BNOT || op == OP_LNOT) begin
      n = 2'd1;
    end else if (op == OP_IF) begin
      n = 2'd3;
    end else if (op <= OP_NE) begin
      n = 2'd2;
    end else begin
      n = 2'd0;
    end
    return n;
  endfunction

  function automatic logic is_bool(input logic [WORD_W-1:0] v);
    return (v == {WORD_W{1'b0}}) || (v == {{(WORD_W-1){1'b0}}, 1'b1});
  endfunction

endpackage
`default_nettype wire

### hw/rtl/rpnse_mdu.sv
`timescale 1ns / 1ps
`default_nettype none
// Bit-serial multiply / unsigned divide sharing a single 65-bit adder.
// One bit per cycle, one pass over the 64 operand bits per operation.
module rpnse_mdu (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic        is_div,
  input  wire logic [63:0] opa,
  input  wire logic [63:0] opb,
  output logic             busy,
  output logic             done,
  output logic [63:0]      quo_prod,
  output logic [63:0]      rem
);

  logic [63:0] acc_r, acc_nxt;
  logic [63:0] x_r, x_nxt;
  logic [63:0] y_r, y_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic        div_r, div_nxt;
  logic [64:0] add_a, add_b;
  logic [65:0] sum;

  always_comb begin
    if (div_r) begin
      add_a = {acc_r, x_r[63]};
      add_b = ~{1'b0, y_r};
    end else begin
      add_a = {1'b0, acc_r};
      add_b = {1'b0, x_r};
    end
    sum = {1'b0, add_a} + {1'b0, add_b} + {65'd0, div_r};
  end

  always_comb begin
    acc_nxt  = acc_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    div_nxt  = div_r;
    if (start) begin
      acc_nxt  = '0;
      x_nxt    = opa;
      y_nxt    = opb;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
      div_nxt  = is_div;
    end else if (busy_r) begin
      if (div_r) begin
        // The carry out of the subtract says the shifted remainder covers the divisor.
        acc_nxt = sum[65] ? sum[63:0] : add_a[63:0];
        x_nxt   = {x_r[62:0], sum[65]};
      end else begin
        if (y_r[0]) begin
          acc_nxt = sum[63:0];
        end
        x_nxt = {x_r[62:0], 1'b0};
        y_nxt = {1'b0, y_r[63:1]};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    cnt_r <= cnt_nxt;
    div_r <= div_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quo_prod = div_r ? x_r : acc_r;
  assign rem      = acc_r;

endmodule
`default_nettype wire

### hw/rtl/rpn_integer_stack_evaluator.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel | Direction | Handshake         | Word
// in_     | input     | in_valid/in_stall | command, operator, operand_value, last_token
// out_    | output    | out_valid/out_stall | result_value, status
// A push is written on acceptance; an operator passes S_RD, if also S_IF, and mul,
// div and mod wait in S_ITER for the 64-step multiply/divide unit. A last token
// then passes S_FIN and S_OUT to read the bottom of the stack and register the
// result; while the previous result has not been taken, it waits in its final state.
// rst_n is synchronous; stack contents are not cleared, only the state, height, error and output valid.
// New words are stalled while an item is in work.
module rpn_integer_stack_evaluator #(
  parameter int STACK_DEPTH = rpnse_pkg::STACK_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_command,
  input  wire logic [4:0]  in_operator,
  input  wire logic signed [63:0] in_operand_value,
  input  wire logic        in_last_token,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic signed [63:0] out_result_value,
  output logic [2:0]       out_status
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int HW = $clog2(STACK_DEPTH + 1);

  rpnse_pkg::state_t  state_r, state_nxt;
  rpnse_pkg::status_t err_r, err_nxt;
  logic [HW-1:0] height_r, height_nxt;
  logic          cmd_r, last_r;
  rpnse_pkg::op_t op_r;
  logic [63:0]   opa_r, opb_r;
  logic          neg_r;
  logic          out_valid_r, out_valid_nxt;
  logic [63:0]   out_value_r;
  rpnse_pkg::status_t out_status_r;

  logic [63:0] mem [STACK_DEPTH];
  logic [63:0] a_q, b_q;
  logic [AW-1:0] ra, rb, wa;
  logic [63:0] wd;
  logic        we;

  logic in_acc;
  logic out_load;
  logic [HW-1:0] h_m1, h_m2, h_m3, need;
  logic [1:0]  in_arity;
  logic        mdu_start, mdu_div, mdu_busy, mdu_done;
  logic [63:0] mdu_q, mdu_rem, mdu_val, ma, mb;
  logic [63:0] res;
  rpnse_pkg::status_t op_err, fin_st;
  logic        is_md;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != rpnse_pkg::S_IDLE);
  // The result register is free once its word is taken at this edge.
  assign out_load = (state_r == rpnse_pkg::S_OUT) && !(out_valid_r && out_stall);
  assign h_m1     = height_r - HW'(1);
  assign h_m2     = height_r - HW'(2);
  assign h_m3     = height_r - HW'(3);
  assign in_arity = rpnse_pkg::arity(in_operator);
  assign need     = HW'(in_arity);
  assign ma       = a_q[63] ? (~a_q + 64'd1) : a_q;
  assign mb       = b_q[63] ? (~b_q + 64'd1) : b_q;
  assign is_md    = (op_r == rpnse_pkg::OP_MUL) || (op_r == rpnse_pkg::OP_DIV) ||
                    (op_r == rpnse_pkg::OP_MOD);

  // Combinational operator results and errors on a = deeper entry, b = top entry.
  always_comb begin
    res    = '0;
    op_err = rpnse_pkg::ST_OK;
    case (op_r)
      rpnse_pkg::OP_ADD:  res = a_q + b_q;
      rpnse_pkg::OP_SUB:  res = a_q - b_q;
      rpnse_pkg::OP_OR:   res = a_q | b_q;
      rpnse_pkg::OP_AND:  res = a_q & b_q;
      rpnse_pkg::OP_XOR:  res = a_q ^ b_q;
      rpnse_pkg::OP_BNOT: res = ~b_q;
      rpnse_pkg::OP_SHL, rpnse_pkg::OP_SHR: begin
        if (b_q > 64'd63) begin
          op_err = rpnse_pkg::ST_SHIFT;
        end else if (op_r == rpnse_pkg::OP_SHL) begin
          res = a_q << b_q[5:0];
        end else begin
          res = $unsigned($signed(a_q) >>> b_q[5:0]);
        end
      end
      rpnse_pkg::OP_LAND, rpnse_pkg::OP_LOR, rpnse_pkg::OP_LXOR: begin
        if (!rpnse_pkg::is_bool(a_q) || !rpnse_pkg::is_bool(b_q)) begin
          op_err = rpnse_pkg::ST_NONBOOL;
        end else if (op_r == rpnse_pkg::OP_LAND) begin
          res = a_q & b_q;
        end else if (op_r == rpnse_pkg::OP_LOR) begin
          res = a_q | b_q;
        end else begin
          res = a_q ^ b_q;
        end
      end
      rpnse_pkg::OP_LNOT: begin
        if (!rpnse_pkg::is_bool(b_q)) begin
          op_err = rpnse_pkg::ST_NONBOOL;
        end else begin
          res = {63'd0, ~b_q[0]};
        end
      end
      rpnse_pkg::OP_LT: res = {63'd0, $signed(a_q) < $signed(b_q)};
      rpnse_pkg::OP_LE: res = {63'd0, !($signed(b_q) < $signed(a_q))};
      rpnse_pkg::OP_GT: res = {63'd0, $signed(b_q) < $signed(a_q)};
      rpnse_pkg::OP_GE: res = {63'd0, !($signed(a_q) < $signed(b_q))};
      rpnse_pkg::OP_EQ: res = {63'd0, a_q == b_q};
      rpnse_pkg::OP_NE: res = {63'd0, a_q != b_q};
      rpnse_pkg::OP_DIV, rpnse_pkg::OP_MOD: begin
        if (b_q == 64'd0) begin
          op_err = rpnse_pkg::ST_DIVZ;
        end
      end
      default: res = '0;
    endcase
  end

  assign mdu_val = (op_r == rpnse_pkg::OP_MOD) ? mdu_rem : mdu_q;

  always_comb begin
    if (err_r != rpnse_pkg::ST_OK) begin
      fin_st = err_r;
    end else if (height_r == '0) begin
      fin_st = rpnse_pkg::ST_EMPTY;
    end else if (height_r >= HW'(2)) begin
      fin_st = rpnse_pkg::ST_MANY;
    end else begin
      fin_st = rpnse_pkg::ST_OK;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rpnse_pkg::S_IDLE: begin
        if (in_acc) begin
          if ((err_r == rpnse_pkg::ST_OK) && (in_command != rpnse_pkg::CMD_PUSH) &&
              (in_arity != 2'd0) && (height_r >= need)) begin
            state_nxt = rpnse_pkg::S_RD;
          end else if (in_last_token) begin
            state_nxt = rpnse_pkg::S_FIN;
          end
        end
      end
      rpnse_pkg::S_RD: begin
        if (op_r == rpnse_pkg::OP_IF) begin
          state_nxt = rpnse_pkg::S_IF;
        end else if (is_md && (op_err == rpnse_pkg::ST_OK)) begin
          state_nxt = rpnse_pkg::S_ITER;
        end else begin
          state_nxt = last_r ? rpnse_pkg::S_FIN : rpnse_pkg::S_IDLE;
        end
      end
      rpnse_pkg::S_IF: state_nxt = last_r ? rpnse_pkg::S_FIN : rpnse_pkg::S_IDLE;
      rpnse_pkg::S_ITER: begin
        if (mdu_done) begin
          state_nxt = last_r ? rpnse_pkg::S_FIN : rpnse_pkg::S_IDLE;
        end
      end
      rpnse_pkg::S_FIN: state_nxt = rpnse_pkg::S_OUT;
      rpnse_pkg::S_OUT: begin
        if (out_load) begin
          state_nxt = rpnse_pkg::S_IDLE;
        end
      end
      default: state_nxt = rpnse_pkg::S_IDLE;
    endcase
  end

  // Datapath control.
  always_comb begin
    we            = 1'b0;
    wa            = height_r[AW-1:0];
    wd            = in_operand_value;
    ra            = h_m2[AW-1:0];
    rb            = h_m1[AW-1:0];
    height_nxt    = height_r;
    err_nxt       = err_r;
    mdu_start     = 1'b0;
    mdu_div       = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      rpnse_pkg::S_IDLE: begin
        if (in_acc && (err_r == rpnse_pkg::ST_OK)) begin
          if (in_command == rpnse_pkg::CMD_PUSH) begin
            if (height_r >= HW'(STACK_DEPTH)) begin
              err_nxt = rpnse_pkg::ST_OVER;
            end else begin
              we         = 1'b1;
              height_nxt = height_r + HW'(1);
            end
          end else if ((in_arity != 2'd0) && (height_r < need)) begin
            err_nxt = rpnse_pkg::ST_UNDER;
          end
        end
      end
      rpnse_pkg::S_RD: begin
        ra = h_m3[AW-1:0];
        if (op_r == rpnse_pkg::OP_IF) begin
          we = 1'b0;
        end else if (op_err != rpnse_pkg::ST_OK) begin
          err_nxt = op_err;
        end else if (is_md) begin
          mdu_start = 1'b1;
          mdu_div   = (op_r != rpnse_pkg::OP_MUL);
        end else if ((op_r == rpnse_pkg::OP_BNOT) || (op_r == rpnse_pkg::OP_LNOT)) begin
          we = 1'b1;
          wa = h_m1[AW-1:0];
          wd = res;
        end else begin
          we         = 1'b1;
          wa         = h_m2[AW-1:0];
          wd         = res;
          height_nxt = h_m1;
        end
      end
      rpnse_pkg::S_IF: begin
        we         = 1'b1;
        wa         = h_m3[AW-1:0];
        wd         = (a_q != 64'd0) ? opa_r : opb_r;
        height_nxt = h_m2;
      end
      rpnse_pkg::S_ITER: begin
        if (mdu_done) begin
          we         = 1'b1;
          wa         = h_m2[AW-1:0];
          wd         = neg_r ? (~mdu_val + 64'd1) : mdu_val;
          height_nxt = h_m1;
        end
      end
      rpnse_pkg::S_FIN: begin
        ra = '0;
      end
      rpnse_pkg::S_OUT: begin
        // Keep the bottom entry on a_q while the previous result waits.
        ra = '0;
        if (out_load) begin
          out_valid_nxt = 1'b1;
          height_nxt    = '0;
          err_nxt       = rpnse_pkg::ST_OK;
        end
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    a_q <= mem[ra];
    b_q <= mem[rb];
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r  <= in_command;
      op_r   <= rpnse_pkg::op_t'(in_operator);
      last_r <= in_last_token;
    end
    if (state_r == rpnse_pkg::S_RD) begin
      if (op_r == rpnse_pkg::OP_IF) begin
        opa_r <= a_q;
        opb_r <= b_q;
      end else begin
        opa_r <= ma;
        opb_r <= mb;
      end
      // The unit works on magnitudes; the sign is restored on write-back.
      neg_r <= (op_r == rpnse_pkg::OP_MOD) ? a_q[63] : (a_q[63] ^ b_q[63]);
    end
    if (out_load) begin
      out_status_r <= fin_st;
      out_value_r  <= (fin_st == rpnse_pkg::ST_OK) ? a_q : 64'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rpnse_pkg::S_IDLE;
      err_r       <= rpnse_pkg::ST_OK;
      height_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      err_r       <= err_nxt;
      height_r    <= height_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  rpnse_mdu u_mdu (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mdu_start),
    .is_div   (mdu_div),
    .opa      (ma),
    .opb      (mb),
    .busy     (mdu_busy),
    .done     (mdu_done),
    .quo_prod (mdu_q),
    .rem      (mdu_rem)
  );

  assign out_valid        = out_valid_r;
  assign out_result_value = $signed(out_value_r);
  assign out_status       = out_status_r;

  // Stack height never exceeds the depth; operand reads only ever follow an operator word.
  a_height_bound: assert property (@(posedge clk) disable iff (!rst_n)
    height_r <= HW'(STACK_DEPTH))
    else $error("stack height beyond depth");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != rpnse_pkg::ST_OK)) |-> (out_result_value == 64'sd0))
    else $error("failed result carries a value");

  a_mdu_state: assert property (@(posedge clk) disable iff (!rst_n)
    mdu_busy |-> (state_r == rpnse_pkg::S_ITER))
    else $error("multiply/divide unit busy outside iteration");

  a_op_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rpnse_pkg::S_RD) |-> (cmd_r != rpnse_pkg::CMD_PUSH))
    else $error("operand read for a push word");

endmodule
`default_nettype wire
